### rtl/pss_pkg.sv
// Shared types, constants and the arctangent table for the polar sector selector.
package pss_pkg;

    localparam int unsigned COORD_BITS     = 12;
    localparam int unsigned MAX_SLOTS      = 16;
    localparam int unsigned ANGLE_BITS_DEF = 16;
    localparam int unsigned ATAN_ENTRIES   = 24;

    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 12;
    localparam int unsigned COUNT_BITS    = 5;
    localparam int unsigned RADIUS_BITS   = 10;
    localparam int unsigned SLOT_BITS     = 4;

    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOT_COUNT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEADZONE_RAD = 3'd3;

    localparam logic [COORD_BITS-1:0]  CENTER_RESET   = '0;
    localparam logic [COUNT_BITS-1:0]  COUNT_RESET    = 5'd16;
    localparam logic [RADIUS_BITS-1:0] DEADZONE_RESET = 10'd38;

    typedef struct packed {
        logic [COORD_BITS-1:0] pointer_x;
        logic [COORD_BITS-1:0] pointer_y;
    } t_in;

    typedef struct packed {
        logic                 slot_valid;
        logic [SLOT_BITS-1:0] slot_index;
    } t_out;

    // Control that travels alongside the vector through the cell chain.
    typedef struct packed {
        logic valid;
        logic skip;
        logic zero;
    } t_side;

    // Arctangent of 2^-i in units of 2^32 per full turn.
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/pss_prep.sv
// Front end: offsets from the center, squared distance test and CORDIC pre-rotation.
module pss_prep
    import pss_pkg::*;
#(
    parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF,
    localparam int unsigned DW = COORD_BITS + ANGLE_BITS + 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  t_in                    i_point,
    input  logic [COORD_BITS-1:0]  i_center_x,
    input  logic [COORD_BITS-1:0]  i_center_y,
    input  logic [RADIUS_BITS-1:0] i_radius,
    input  logic                   i_count_zero,
    output logic signed [DW-1:0]   o_x,
    output logic signed [DW-1:0]   o_y,
    output logic [31:0]            o_z,
    output t_side                  o_side
);

    localparam int unsigned DxW = COORD_BITS + 1;
    localparam int unsigned SqW = 2 * COORD_BITS;
    localparam int unsigned R2W = 2 * RADIUS_BITS;

    logic                  r_vld_a;
    logic signed [DxW-1:0] r_dx;
    logic signed [DxW-1:0] r_dy;
    logic [R2W-1:0]        r_r2;

    logic                  r_vld_b;
    logic                  r_zero;
    logic [SqW-1:0]        r_dx2;
    logic [SqW-1:0]        r_dy2;
    logic signed [DW-1:0]  r_x;
    logic signed [DW-1:0]  r_y;
    logic [31:0]           r_z;

    logic signed [2*DxW-1:0] n_dx2;
    logic signed [2*DxW-1:0] n_dy2;
    logic signed [DW-1:0]    n_dxs;
    logic signed [DW-1:0]    n_dys;
    logic [SqW:0]            n_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            r_vld_a <= i_accept;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_dx <= $signed({1'b0, i_point.pointer_x}) - $signed({1'b0, i_center_x});
            r_dy <= $signed({1'b0, i_point.pointer_y}) - $signed({1'b0, i_center_y});
        end
        r_r2 <= i_radius * i_radius;
    end

    always_comb begin
        n_dx2 = r_dx * r_dx;
        n_dy2 = r_dy * r_dy;
        n_dxs = DW'(r_dx) <<< ANGLE_BITS;
        n_dys = DW'(r_dy) <<< ANGLE_BITS;
    end

    // The CORDIC works on (-dy, dx); a negative first operand is turned by a half turn.
    always_ff @(posedge i_clk) begin
        r_dx2  <= n_dx2[SqW-1:0];
        r_dy2  <= n_dy2[SqW-1:0];
        r_zero <= (r_dx == '0) && (r_dy == '0);
        if (r_dy > 0) begin
            r_x <= n_dys;
            r_y <= -n_dxs;
            r_z <= 32'h8000_0000;
        end else begin
            r_x <= -n_dys;
            r_y <= n_dxs;
            r_z <= 32'h0000_0000;
        end
    end

    assign n_d2 = {1'b0, r_dx2} + {1'b0, r_dy2};

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

    always_comb begin
        o_side.valid = r_vld_b;
        o_side.skip  = i_count_zero || (n_d2 < (SqW+1)'(r_r2));
        o_side.zero  = r_zero;
    end

endmodule

### rtl/pss_cell.sv
// One vectoring CORDIC iteration with its pipeline register.
module pss_cell
    import pss_pkg::*;
#(
    parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int unsigned STAGE      = 0,
    localparam int unsigned DW = COORD_BITS + ANGLE_BITS + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic [31:0]          i_z,
    input  t_side                i_side,
    output logic signed [DW-1:0] o_x,
    output logic signed [DW-1:0] o_y,
    output logic [31:0]          o_z,
    output t_side                o_side
);

    localparam logic [31:0] Atan = atan_turn(STAGE);

    logic signed [DW-1:0] r_x;
    logic signed [DW-1:0] r_y;
    logic [31:0]          r_z;
    logic                 r_vld;
    logic                 r_skip;
    logic                 r_zero;

    logic signed [DW-1:0] n_xs;
    logic signed [DW-1:0] n_ys;

    assign n_xs = i_x >>> STAGE;
    assign n_ys = i_y >>> STAGE;

    always_ff @(posedge i_clk) begin
        if (i_y < 0) begin
            r_x <= i_x - n_ys;
            r_y <= i_y + n_xs;
            r_z <= i_z - Atan;
        end else begin
            r_x <= i_x + n_ys;
            r_y <= i_y - n_xs;
            r_z <= i_z + Atan;
        end
        r_skip <= i_side.skip;
        r_zero <= i_side.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_side.valid;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

    always_comb begin
        o_side.valid = r_vld;
        o_side.skip  = r_skip;
        o_side.zero  = r_zero;
    end

endmodule

### rtl/pss_quant.sv
// Back end: rounds the CORDIC angle and maps it to a sector index.
module pss_quant
    import pss_pkg::*;
#(
    parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [31:0]           i_z,
    input  t_side                 i_side,
    input  logic [COUNT_BITS-1:0] i_count,
    output t_out                  o_result,
    output logic                  o_strobe
);

    localparam int unsigned PW = ANGLE_BITS + COUNT_BITS + 1;
    localparam logic [31:0] RoundBit = 32'(1) << (31 - ANGLE_BITS);
    localparam logic [ANGLE_BITS-1:0] QuarterTurn = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [PW-1:0] HalfUnit = PW'(1) << (ANGLE_BITS - 1);

    logic [ANGLE_BITS-1:0] r_ang;
    logic                  r_skip;
    logic                  r_vld;
    t_out                  r_out;
    logic                  r_strobe;

    logic [31:0]           n_zr;
    logic [PW-1:0]         n_sum;
    logic [COUNT_BITS-1:0] n_q;
    logic [COUNT_BITS-1:0] n_slot;

    assign n_zr = i_z + RoundBit;

    always_ff @(posedge i_clk) begin
        r_ang  <= i_side.zero ? QuarterTurn : n_zr[31 -: ANGLE_BITS];
        r_skip <= i_side.skip;
    end

    // The quotient never exceeds the count, so the wrap is a single compare.
    always_comb begin
        n_sum  = PW'(r_ang) * PW'(i_count) + HalfUnit;
        n_q    = n_sum[ANGLE_BITS +: COUNT_BITS];
        n_slot = (n_q == i_count) ? '0 : n_q;
    end

    always_ff @(posedge i_clk) begin
        r_out.slot_valid <= !r_skip;
        r_out.slot_index <= r_skip ? '0 : n_slot[SLOT_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= i_side.valid;
            r_strobe <= r_vld;
        end
    end

    assign o_result = r_out;
    assign o_strobe = r_strobe;

endmodule

### rtl/polar_sector_select.sv
// Top level of the polar sector selector: registers, front end, CORDIC cell chain, back end.
//
//  Channel   Signals                                   Direction  Handshake
//  --------  ----------------------------------------  ---------  ---------------------------
//  point     start, busy, i_point                      in         start & !busy
//  result    o_result_strobe, o_result                 out        strobe, one cycle, no stall
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,    in         valid & ready
//            i_cfg_data
//
// One word is accepted every cycle; busy is never raised.
// The pipeline is a chain of min(ANGLE_BITS, 24) CORDIC cells, one iteration per cell,
// plus two front and two back stages.
// Reset clears the valid pipeline and loads the register defaults; nothing else.
// Results cannot be held off by the receiver, and none is needed.
module polar_sector_select
    import pss_pkg::*;
#(
    parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  t_in                      i_point,
    output logic                     o_result_strobe,
    output t_out                     o_result,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int unsigned NCELL = (ANGLE_BITS < ATAN_ENTRIES) ? ANGLE_BITS : ATAN_ENTRIES;
    localparam int unsigned DW    = COORD_BITS + ANGLE_BITS + 3;

    logic [COORD_BITS-1:0]  r_center_x;
    logic [COORD_BITS-1:0]  r_center_y;
    logic [COUNT_BITS-1:0]  r_slot_count;
    logic [RADIUS_BITS-1:0] r_deadzone;

    logic [COUNT_BITS-1:0]  w_count;
    logic                   w_accept;

    logic signed [DW-1:0] w_x    [0:NCELL];
    logic signed [DW-1:0] w_y    [0:NCELL];
    logic [31:0]          w_z    [0:NCELL];
    t_side                w_side [0:NCELL];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= CENTER_RESET;
            r_center_y   <= CENTER_RESET;
            r_slot_count <= COUNT_RESET;
            r_deadzone   <= DEADZONE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_CENTER_X:     r_center_x   <= i_cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y:     r_center_y   <= i_cfg_data[COORD_BITS-1:0];
                REG_SLOT_COUNT:   r_slot_count <= i_cfg_data[COUNT_BITS-1:0];
                REG_DEADZONE_RAD: r_deadzone   <= i_cfg_data[RADIUS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Counts beyond the supported number of sectors are clamped.
    always_comb begin
        if (32'(r_slot_count) > MAX_SLOTS) begin
            w_count = COUNT_BITS'(MAX_SLOTS);
        end else begin
            w_count = r_slot_count;
        end
    end

    pss_prep #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_point      (i_point),
        .i_center_x   (r_center_x),
        .i_center_y   (r_center_y),
        .i_radius     (r_deadzone),
        .i_count_zero (w_count == '0),
        .o_x          (w_x[0]),
        .o_y          (w_y[0]),
        .o_z          (w_z[0]),
        .o_side       (w_side[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        pss_cell #(
            .ANGLE_BITS (ANGLE_BITS),
            .STAGE      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_side  (w_side[g]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    pss_quant #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_quant (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_z      (w_z[NCELL]),
        .i_side   (w_side[NCELL]),
        .i_count  (w_count),
        .o_result (o_result),
        .o_strobe (o_result_strobe)
    );

endmodule

### dv/pss_slot_checker.sv
// Checker for the polar sector selector: predicts the sector of each accepted point and compares.
`timescale 1ns / 100ps

module pss_slot_checker
    import pss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  t_in                      i_point,
    input  logic                     i_result_strobe,
    input  t_out                     i_result,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int unsigned ANGLE_BITS  = ANGLE_BITS_DEF;
    localparam int unsigned ANGLE_ITERS = (ANGLE_BITS < 24) ? ANGLE_BITS : 24;

    // Arctangent of 2^-i, 2^32 units per full turn.
    localparam logic [31:0] ATAN_TURN [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    logic [COORD_BITS-1:0]  cen_x;
    logic [COORD_BITS-1:0]  cen_y;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic [RADIUS_BITS-1:0] rad_reg;

    t_out pending_slots[$];
    int   mismatch_cnt;

    function automatic t_out predict_slot(t_in p);
        longint            px, py, cx, cy, dx, dy, d2, r2, rad, x, y, xs, ys;
        logic [31:0]       z;
        longint unsigned   ang, cnt, slot;
        t_out              r;
        r   = '0;
        px  = p.pointer_x;
        py  = p.pointer_y;
        cx  = cen_x;
        cy  = cen_y;
        rad = rad_reg;
        cnt = cnt_reg;
        if (cnt > MAX_SLOTS) cnt = MAX_SLOTS;
        dx = px - cx;
        dy = py - cy;
        d2 = dx * dx + dy * dy;
        r2 = rad * rad;
        if (cnt == 0 || d2 < r2) return r;

        if (dx == 0 && dy == 0) begin
            // A pointer on the center reads as pointing right.
            ang = 64'd1 << (ANGLE_BITS - 2);
        end else begin
            // Vectoring rotation; x points up on screen, y points right.
            x = -dy * (64'sd1 <<< ANGLE_BITS);
            y = dx * (64'sd1 <<< ANGLE_BITS);
            z = '0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 32'h8000_0000;
            end
            for (int i = 0; i < ANGLE_ITERS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y < 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_TURN[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_TURN[i];
                end
            end
            ang = ({32'd0, z} + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
            ang = ang & ((64'd1 << ANGLE_BITS) - 1);
        end
        slot = ((ang * cnt + (64'd1 << (ANGLE_BITS - 1))) >> ANGLE_BITS) % cnt;
        r.slot_valid = 1'b1;
        r.slot_index = slot[SLOT_BITS-1:0];
        return r;
    endfunction

    initial begin
        mismatch_cnt = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            cen_x   = CENTER_RESET;
            cen_y   = CENTER_RESET;
            cnt_reg = COUNT_RESET;
            rad_reg = DEADZONE_RESET;
            pending_slots.delete();
        end else begin
            if (i_result_strobe) begin
                if (pending_slots.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("%0t: sector word %b/%0d arrived with none outstanding",
                                 $realtime, i_result.slot_valid, i_result.slot_index);
                    mismatch_cnt++;
                end else begin
                    want = pending_slots.pop_front();
                    if (i_result.slot_valid !== want.slot_valid ||
                        i_result.slot_index !== want.slot_index) begin
                        if (mismatch_cnt < 10)
                            $display("%0t: sector mismatch: valid %b index %0d, wanted %b %0d",
                                     $realtime, i_result.slot_valid, i_result.slot_index,
                                     want.slot_valid, want.slot_index);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CENTER_X:     cen_x   = i_cfg_data[COORD_BITS-1:0];
                    REG_CENTER_Y:     cen_y   = i_cfg_data[COORD_BITS-1:0];
                    REG_SLOT_COUNT:   cnt_reg = i_cfg_data[COUNT_BITS-1:0];
                    REG_DEADZONE_RAD: rad_reg = i_cfg_data[RADIUS_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                pending_slots = {pending_slots, predict_slot(i_point)};
        end
        o_fail_count <= mismatch_cnt;
        o_pending    <= pending_slots.size();
    end

endmodule

### dv/tb_polar_sector_select.sv
// Testbench top for the polar sector selector: clock, reset, point and register stimulus, verdict.
`timescale 1ns / 100ps

module tb_polar_sector_select;
    import pss_pkg::*;

    localparam int PIPE_LATENCY = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 115;
    // An index that maps to no register; writes to it must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd5;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    t_in                      i_point;
    logic                     o_result_strobe;
    t_out                     o_result;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int cycle_cnt;

    polar_sector_select dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_point         (i_point),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    pss_slot_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_point         (i_point),
        .i_result_strobe (o_result_strobe),
        .i_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offers one point word and returns at the edge that takes it.
    task automatic send_point(input logic [11:0] px, input logic [11:0] py);
        i_point <= '{pointer_x: px, pointer_y: py};
        start   <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_regs(input logic [11:0] cx, input logic [11:0] cy,
                            input logic [11:0] cnt, input logic [11:0] rad);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_SLOT_COUNT, cnt);
        write_reg(REG_DEADZONE_RAD, rad);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [11:0] cx, cy, cnt_data, rad, px, py;
        int          spread, sel;
        bit          gaps_on;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_point     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: center at the origin, 16 sectors, dead zone of 38.
        send_point(12'd0, 12'd0);
        send_point(12'd38, 12'd0);
        send_point(12'd37, 12'd0);
        idle(3);
        send_point(12'd4095, 12'd4095);
        send_point(12'd0, 12'd4095);
        send_point(12'd4095, 12'd0);
        wait_drain();

        write_reg(REG_UNUSED, 12'hFFF);
        set_regs(12'd2048, 12'd2048, 12'd16, 12'd0);
        // Pointer on the center, the four axes, either side of straight up, and two corners.
        send_point(12'd2048, 12'd2048);
        send_point(12'd2048, 12'd0);
        send_point(12'd4095, 12'd2048);
        send_point(12'd2048, 12'd4095);
        send_point(12'd0, 12'd2048);
        send_point(12'd2047, 12'd0);
        send_point(12'd2049, 12'd0);
        send_point(12'd0, 12'd0);
        send_point(12'd4095, 12'd4095);
        wait_drain();

        // No sectors at all.
        set_regs(12'd4095, 12'd4095, 12'd0, 12'd0);
        send_point(12'd0, 12'd0);
        send_point(12'd4095, 12'd4095);
        wait_drain();

        // Count with upper data bits set clamps to the maximum; widest dead zone.
        set_regs(12'd4095, 12'd0, 12'hFF7, 12'hFFF);
        send_point(12'd0, 12'd4095);
        send_point(12'd3072, 12'd0);
        send_point(12'd3073, 12'd0);
        send_point(12'd0, 12'd0);
        wait_drain();

        set_regs(12'd100, 12'd100, 12'd1, 12'd5);
        send_point(12'd4095, 12'd4095);
        send_point(12'd0, 12'd0);
        wait_drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            cx  = 12'($urandom_range(0, 4095));
            cy  = 12'($urandom_range(0, 4095));
            sel = $urandom % 8;
            if (sel == 0)
                cnt_data = 12'd0;
            else if (sel == 1)
                cnt_data = 12'd16;
            else if (sel == 2)
                cnt_data = {7'($urandom), 5'($urandom_range(17, 31))};
            else
                cnt_data = {7'($urandom), 5'($urandom_range(1, 16))};
            if ($urandom % 4 == 0)
                rad = {2'($urandom), 10'($urandom_range(0, 1023))};
            else
                rad = 12'($urandom_range(0, 60));
            set_regs(cx, cy, cnt_data, rad);

            gaps_on = 1'b0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 30 == 0)
                    gaps_on = (ph != RAND_PHASES - 1) && ($urandom % 3 != 0);
                if ($urandom % 10 < 6) begin
                    px = 12'($urandom);
                    py = 12'($urandom);
                end else begin
                    // Land close to the center so the dead-zone edge gets hit.
                    spread = int'(rad[9:0]) + 3;
                    px = 12'(cx + $urandom_range(0, 2 * spread) - spread);
                    py = 12'(cy + $urandom_range(0, 2 * spread) - spread);
                end
                send_point(px, py);
                if (ph == 1 && k == 57)
                    wait_drain();
                else if (gaps_on && $urandom % 4 == 0)
                    idle($urandom_range(1, 9));
            end
            wait_drain();
        end

        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
rtl/pss_pkg.sv
rtl/pss_prep.sv
rtl/pss_cell.sv
rtl/pss_quant.sv
rtl/polar_sector_select.sv
dv/pss_slot_checker.sv
dv/tb_polar_sector_select.sv
